### hdl/vector_segment_point_stepper_unit_macros.svh
// Assertion macros for the segment point stepper.
// Used by vector_segment_point_stepper_unit; no other dependencies.
`ifndef VECTOR_SEGMENT_POINT_STEPPER_UNIT_MACROS_SVH
`define VECTOR_SEGMENT_POINT_STEPPER_UNIT_MACROS_SVH
`ifndef SYNTH
// condition must hold at every clock outside reset
`define VSPS_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("vsps assertion failed");
// antecedent implies consequent in the next cycle
`define VSPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vsps assertion failed");
`else
`define VSPS_ASSERT(lbl, cond)
`define VSPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/vsps_pkg.sv
// Package for the segment point stepper: payload types, sequencer states,
// constants and the screen mapping function. No dependencies.
package vsps_pkg;

    localparam int MAX_POINTS = 64;
    localparam int FRAC_BITS  = 8;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    // width of the shared compare/subtract unit
    localparam int UW         = 21;

    typedef struct packed {
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic               laser_on;
        logic [10:0]        step_length;
    } seg_t;

    typedef struct packed {
        logic [7:0] screen_x;
        logic [7:0] screen_y;
        logic       beam;
        logic       last;
        logic       truncated;
    } point_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_EMIT,
        ST_SQRT,
        ST_CHK,
        ST_MULX,
        ST_LDX,
        ST_DIVX,
        ST_MULY,
        ST_LDY,
        ST_DIVY
    } state_t;

    // floor(raw / 2^(FRAC_BITS-1)) + 128, clamped to 0..255
    function automatic logic [7:0] screen_map(input logic signed [16:0] raw);
        logic signed [17:0] v;
        v = 18'(raw >>> (FRAC_BITS - 1)) + 18'sd128;
        if (v < 18'sd0)
            return 8'd0;
        else if (v > 18'sd255)
            return 8'd255;
        else
            return v[7:0];
    endfunction

endpackage

### hdl/vsps_sub_unit.sv
// Shared restoring step: compares a trial value against the remainder and
// gives the difference. Used by both square root and division. Needs vsps_pkg.
module vsps_sub_unit
    import vsps_pkg::*;
(
    input  logic [UW-1:0] a,
    input  logic [UW-1:0] b,
    output logic          ge,
    output logic [UW-1:0] diff
);

    logic [UW:0] sub;

    // one wide subtract; the borrow gives the compare
    assign sub  = {1'b0, a} - {1'b0, b};
    assign ge   = ~sub[UW];
    assign diff = sub[UW-1:0];

endmodule

### hdl/vector_segment_point_stepper_unit.sv
// Top level of the segment point stepper: sequencer, multiplier, output register.
// Depends on vsps_pkg, vsps_sub_unit and vector_segment_point_stepper_unit_macros.svh.
//
// A segment request enters on seg (seg_valid/seg_ready). Points leave on pt
// (pt_valid/pt_ready), one or more per request, start point first, then one
// point per whole step along the segment, then the exact end point; last marks
// the final point and truncated marks a segment cut at MAX_POINTS points.
// seg_ready is high only while the sequencer is idle: one segment at a time.
// Steps with an open receiver: ST_SQX, ST_SQY and ST_SUM form the squared length,
// then ST_EMIT sends the start point; a nonzero length adds the bit-pair square root.
// Each inner point takes a check, two multiplies, two 17-step divisions
// on the shared compare/subtract unit at one bit per cycle, and its emit, and
// the end point a check and an emit. A new segment is taken in the idle state
// only, after the last point of the one before has been loaded.
// Points sit in one output register; a new point is loaded in the cycle the
// old one is taken, so a stalled receiver only holds the sequencer in its
// emit state. Reset clears the sequencer and the output valid; no point is
// pending afterward and the block is ready for a segment at once.
`include "vector_segment_point_stepper_unit_macros.svh"

module vector_segment_point_stepper_unit
    import vsps_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   seg_valid,
    output logic   seg_ready,
    input  seg_t   seg,
    output logic   pt_valid,
    input  logic   pt_ready,
    output point_t pt
);

    state_t state_reg, state_next;
    logic signed [15:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [15:0] ex_reg, ex_next, ey_reg, ey_next;
    logic        beam_reg, beam_next;
    logic [10:0] step_reg, step_next;
    logic [15:0] mdx_reg, mdx_next, mdy_reg, mdy_next;
    logic        negx_reg, negx_next, negy_reg, negy_next;
    logic [32:0] prod_reg, prod_next;
    logic [33:0] dsq_reg, dsq_next;
    logic [UW-3:0] rem_reg, rem_next;
    logic [16:0] root_reg, root_next;
    logic [16:0] t_reg, t_next;
    logic [16:0] quo_reg, quo_next;
    logic [4:0]  iter_reg, iter_next;
    logic signed [16:0] ptx_reg, ptx_next, pty_reg, pty_next;
    logic        plast_reg, plast_next, ptrunc_reg, ptrunc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    point_t      out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic [15:0] mul_a;
    logic [16:0] mul_b;
    logic [32:0] mul_p;
    logic [UW-1:0] ua, ub, udiff;
    logic        uge;
    logic signed [16:0] dx_in, dy_in;
    logic [33:0] dsq_sum;
    logic [16:0] quo_new;
    logic signed [17:0] coord;
    logic        slot_free;

    vsps_sub_unit u_sub (
        .a    (ua),
        .b    (ub),
        .ge   (uge),
        .diff (udiff)
    );

    assign seg_ready = (state_reg == ST_IDLE);
    assign pt_valid  = out_valid_reg;
    assign pt        = out_reg;
    assign slot_free = ~out_valid_reg | pt_ready;

    assign dx_in   = 17'(seg.end_x) - 17'(seg.start_x);
    assign dy_in   = 17'(seg.end_y) - 17'(seg.start_y);
    assign mul_p   = mul_a * mul_b;
    assign dsq_sum = dsq_reg + 34'(prod_reg);
    assign quo_new = {quo_reg[15:0], uge};

    // shared multiplier operands
    always_comb
    begin
        mul_a = mdx_reg;
        mul_b = {1'b0, mdx_reg};
        unique case (state_reg)
            ST_SQY:  begin mul_a = mdy_reg; mul_b = {1'b0, mdy_reg}; end
            ST_MULX: begin mul_a = mdx_reg; mul_b = t_reg; end
            ST_MULY: begin mul_a = mdy_reg; mul_b = t_reg; end
            default: ;
        endcase
    end

    // shared compare/subtract operands: square root pair or division bit
    always_comb
    begin
        if (state_reg == ST_SQRT)
        begin
            ua = {rem_reg, dsq_reg[33:32]};
            ub = UW'({root_reg, 2'b01});
        end
        else
        begin
            ua = UW'({rem_reg[16:0], quo_reg[16]});
            ub = UW'(root_reg);
        end
    end

    // signed coordinate from the division result
    always_comb
    begin
        if (state_reg == ST_DIVX)
            coord = negx_reg ? 18'(sx_reg) - 18'(quo_new) : 18'(sx_reg) + 18'(quo_new);
        else
            coord = negy_reg ? 18'(sy_reg) - 18'(quo_new) : 18'(sy_reg) + 18'(quo_new);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        beam_next      = beam_reg;
        step_next      = step_reg;
        mdx_next       = mdx_reg;
        mdy_next       = mdy_reg;
        negx_next      = negx_reg;
        negy_next      = negy_reg;
        prod_next      = prod_reg;
        dsq_next       = dsq_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        t_next         = t_reg;
        quo_next       = quo_reg;
        iter_next      = iter_reg;
        ptx_next       = ptx_reg;
        pty_next       = pty_reg;
        plast_next     = plast_reg;
        ptrunc_next    = ptrunc_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & ~pt_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (seg_valid)
                begin
                    sx_next   = seg.start_x;
                    sy_next   = seg.start_y;
                    ex_next   = seg.end_x;
                    ey_next   = seg.end_y;
                    beam_next = seg.laser_on;
                    step_next = (seg.step_length == 11'd0) ? 11'd1 : seg.step_length;
                    negx_next = dx_in[16];
                    negy_next = dy_in[16];
                    mdx_next  = dx_in[16] ? 16'(-dx_in) : dx_in[15:0];
                    mdy_next  = dy_in[16] ? 16'(-dy_in) : dy_in[15:0];
                    cnt_next  = '0;
                    state_next = ST_SQX;
                end
            end
            ST_SQX:
            begin
                prod_next  = mul_p;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                dsq_next   = 34'(prod_reg);
                prod_next  = mul_p;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                dsq_next    = dsq_sum;
                ptx_next    = 17'(sx_reg);
                pty_next    = 17'(sy_reg);
                plast_next  = (dsq_sum == 34'd0);
                ptrunc_next = 1'b0;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_next.screen_x  = screen_map(ptx_reg);
                    out_next.screen_y  = screen_map(pty_reg);
                    out_next.beam      = beam_reg;
                    out_next.last      = plast_reg;
                    out_next.truncated = ptrunc_reg;
                    out_valid_next     = 1'b1;
                    cnt_next           = cnt_reg + 1'b1;
                    if (plast_reg)
                        state_next = ST_IDLE;
                    else if (cnt_reg == '0)
                    begin
                        rem_next   = '0;
                        root_next  = '0;
                        iter_next  = '0;
                        state_next = ST_SQRT;
                    end
                    else
                    begin
                        t_next     = t_reg + 17'(step_reg);
                        state_next = ST_CHK;
                    end
                end
            end
            ST_SQRT:
            begin
                // one result bit per cycle, two radicand bits consumed
                dsq_next = {dsq_reg[31:0], 2'b00};
                if (uge)
                begin
                    rem_next  = udiff[UW-3:0];
                    root_next = {root_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_next  = ua[UW-3:0];
                    root_next = {root_reg[15:0], 1'b0};
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == 5'd16)
                begin
                    t_next     = 17'(step_reg);
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (t_reg < root_reg)
                begin
                    plast_next  = (cnt_reg == CNT_W'(MAX_POINTS - 1));
                    ptrunc_next = (cnt_reg == CNT_W'(MAX_POINTS - 1));
                    state_next  = ST_MULX;
                end
                else
                begin
                    ptx_next    = 17'(ex_reg);
                    pty_next    = 17'(ey_reg);
                    plast_next  = 1'b1;
                    ptrunc_next = 1'b0;
                    state_next  = ST_EMIT;
                end
            end
            ST_MULX, ST_MULY:
            begin
                prod_next  = mul_p;
                state_next = (state_reg == ST_MULX) ? ST_LDX : ST_LDY;
            end
            ST_LDX, ST_LDY:
            begin
                rem_next   = (UW-2)'(prod_reg[32:17]);
                quo_next   = prod_reg[16:0];
                iter_next  = '0;
                state_next = (state_reg == ST_LDX) ? ST_DIVX : ST_DIVY;
            end
            ST_DIVX, ST_DIVY:
            begin
                // restoring division, one quotient bit per cycle
                if (uge)
                    rem_next = udiff[UW-3:0];
                else
                    rem_next = (UW-2)'(ua[16:0]);
                quo_next  = quo_new;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == 5'd16)
                begin
                    if (state_reg == ST_DIVX)
                    begin
                        ptx_next   = coord[16:0];
                        state_next = ST_MULY;
                    end
                    else
                    begin
                        pty_next   = coord[16:0];
                        state_next = ST_EMIT;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        ex_reg     <= ex_next;
        ey_reg     <= ey_next;
        beam_reg   <= beam_next;
        step_reg   <= step_next;
        mdx_reg    <= mdx_next;
        mdy_reg    <= mdy_next;
        negx_reg   <= negx_next;
        negy_reg   <= negy_next;
        prod_reg   <= prod_next;
        dsq_reg    <= dsq_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        t_reg      <= t_next;
        quo_reg    <= quo_next;
        iter_reg   <= iter_next;
        ptx_reg    <= ptx_next;
        pty_reg    <= pty_next;
        plast_reg  <= plast_next;
        ptrunc_reg <= ptrunc_next;
        out_reg    <= out_next;
    end

    // checks
    `VSPS_ASSERT(a_cnt_cap, cnt_reg <= CNT_W'(MAX_POINTS))
    `VSPS_ASSERT(a_trunc_last, !out_valid_reg || !out_reg.truncated || out_reg.last)
    `VSPS_ASSERT_NEXT(a_accept_clears, seg_valid && seg_ready, cnt_reg == '0 && state_reg == ST_SQX)
    `VSPS_ASSERT_NEXT(a_emit_loads, state_reg == ST_EMIT && slot_free, out_valid_reg)

endmodule

### verif/tb_top.sv
// Self-checking bench for vector_segment_point_stepper_unit: directed segments, then random ones.
// Needs vsps_pkg and the RTL. Points are checked against an in-bench predictor or typed-in ones.
module tb_top;
    import vsps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_SEGS  = 200;
    localparam int CALM_TAIL    = 40;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   seg_valid = 1'b0;
    logic   seg_ready;
    seg_t   seg = '0;
    logic   pt_valid;
    logic   pt_ready = 1'b0;
    point_t pt;

    point_t expected_points[$];
    int     mismatches = 0;
    int     points_checked = 0;
    int     cut_segments = 0;
    int     segs_sent = 0;
    int     quiet_cycles = 0;
    bit     calm = 1'b0;

    typedef struct {
        seg_t   s;
        bit     known;
        point_t p;
    } seg_row_t;

    vector_segment_point_stepper_unit dut (
        .clk(clk), .rst_n(rst_n),
        .seg_valid(seg_valid), .seg_ready(seg_ready), .seg(seg),
        .pt_valid(pt_valid), .pt_ready(pt_ready), .pt(pt)
    );

    always #2 clk = ~clk;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("MISMATCH %s: got %0d expected %0d (point %0d)", what, got, want,
                 points_checked);
    endtask

    // floor(raw / 128) + 128, clamped to the screen
    function automatic logic [7:0] to_pixel(input longint signed raw);
        longint signed v;
        v = (raw >>> (FRAC_BITS - 1)) + 128;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    // bit-pair integer square root
    function automatic longint unsigned root_floor(input longint unsigned d);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > d)
            b >>= 2;
        while (b != 0)
        begin
            if (d >= r + b)
            begin
                d -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // d * t / len, truncated toward zero
    function automatic longint signed along(input longint signed d, input longint unsigned t,
                                            input longint unsigned len);
        longint unsigned q;
        q = ((d < 0 ? -d : d) * t) / len;
        return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    // Queue every point the segment should produce
    task automatic predict_points(input seg_t s);
        point_t          pts[$];
        point_t          p;
        longint signed   sx, sy, dx, dy;
        longint unsigned step, len, t;
        bit              cut;
        sx = s.start_x;
        sy = s.start_y;
        dx = longint'(s.end_x) - sx;
        dy = longint'(s.end_y) - sy;
        step = (s.step_length == 0) ? 1 : s.step_length;
        cut = 1'b0;
        p = '0;
        p.beam = s.laser_on;
        p.screen_x = to_pixel(sx);
        p.screen_y = to_pixel(sy);
        pts.insert(pts.size(), p);
        if (dx != 0 || dy != 0)
        begin
            len = root_floor(longint'(dx * dx + dy * dy));
            for (t = step; t < len && !cut; t += step)
            begin
                if (pts.size() >= MAX_POINTS)
                    cut = 1'b1;
                else
                begin
                    p.screen_x = to_pixel(sx + along(dx, t, len));
                    p.screen_y = to_pixel(sy + along(dy, t, len));
                    pts.insert(pts.size(), p);
                end
            end
            if (pts.size() >= MAX_POINTS)
                cut = 1'b1;
            else
            begin
                p.screen_x = to_pixel(s.end_x);
                p.screen_y = to_pixel(s.end_y);
                pts.insert(pts.size(), p);
            end
        end
        pts[pts.size() - 1].last = 1'b1;
        pts[pts.size() - 1].truncated = cut;
        if (cut)
            cut_segments++;
        foreach (pts[i])
            expected_points.insert(expected_points.size(), pts[i]);
    endtask

    // Hold one segment request until taken; valid stays up unless a gap follows
    task automatic send_segment(input seg_t s, input bit known, input point_t p);
        seg <= s;
        seg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!seg_ready);
        segs_sent++;
        if (known)
            expected_points.insert(expected_points.size(), p);
        else
            predict_points(s);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            seg_valid <= 1'b0;
            repeat ($urandom_range(1, 18))
                @(posedge clk);
        end
    endtask

    function automatic seg_t random_segment();
        seg_t s;
        int   span;
        int   mode;
        mode = $urandom_range(0, 9);
        span = (mode < 3) ? 32767 : ((mode < 8) ? 2047 : 127);
        s.start_x = 16'($signed($urandom_range(0, 2 * span)) - span);
        s.start_y = 16'($signed($urandom_range(0, 2 * span)) - span);
        s.end_x = 16'($signed($urandom_range(0, 2 * span)) - span);
        s.end_y = 16'($signed($urandom_range(0, 2 * span)) - span);
        if (mode < 3 && $urandom_range(0, 1))
        begin
            s.start_x = 16'($urandom);
            s.end_y = 16'($urandom);
        end
        if ($urandom_range(0, 15) == 0)
            s.end_x = s.start_x;
        if ($urandom_range(0, 15) == 0)
            s.end_y = s.start_y;
        s.laser_on = 1'($urandom);
        case ($urandom_range(0, 9))
            0:       s.step_length = 11'($urandom);
            1:       s.step_length = 11'($urandom_range(0, 8));
            default: s.step_length = 11'($urandom_range(span / 40 + 1, 1024));
        endcase
        return s;
    endfunction

    // Receiver: random stall bursts, checks every taken point
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (rst_n && pt_valid && pt_ready)
        begin
            if (expected_points.size() == 0)
            begin
                mismatches++;
                $display("UNEXPECTED point %0d/%0d with nothing pending", pt.screen_x,
                         pt.screen_y);
            end
            else
            begin
                point_t w;
                w = expected_points.pop_front();
                if (pt.screen_x !== w.screen_x)
                    report("screen_x", pt.screen_x, w.screen_x);
                if (pt.screen_y !== w.screen_y)
                    report("screen_y", pt.screen_y, w.screen_y);
                if (pt.beam !== w.beam)
                    report("beam", pt.beam, w.beam);
                if (pt.last !== w.last)
                    report("last", pt.last, w.last);
                if (pt.truncated !== w.truncated)
                    report("truncated", pt.truncated, w.truncated);
            end
            points_checked++;
        end
        if (calm)
            pt_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            pt_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 17);
            pt_ready <= 1'b0;
        end
        else
            pt_ready <= 1'b1;
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((seg_valid && seg_ready) || (pt_valid && pt_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Directed segments: zero length extremes typed in, the rest predicted
    function automatic seg_row_t row(input int sx, input int sy, input int ex, input int ey,
                                     input bit las, input int st, input bit known,
                                     input logic [7:0] px, input logic [7:0] py);
        seg_row_t r;
        r.s = '{16'(sx), 16'(sy), 16'(ex), 16'(ey), las, 11'(st)};
        r.known = known;
        r.p = '{px, py, las, 1'b1, 1'b0};
        return r;
    endfunction

    initial
    begin
        seg_row_t rows[$];
        rows.insert(rows.size(), row(0, 0, 0, 0, 1, 256, 1, 8'd128, 8'd128));
        rows.insert(rows.size(), row(-32768, -32768, -32768, -32768, 0, 1, 1, 8'd0, 8'd0));
        rows.insert(rows.size(), row(32767, 32767, 32767, 32767, 1, 1024, 1, 8'd255, 8'd255));
        rows.insert(rows.size(), row(-128, 127, -128, 127, 1, 0, 1, 8'd127, 8'd128));
        rows.insert(rows.size(), row(0, 0, 1024, 0, 1, 256, 0, 0, 0));
        rows.insert(rows.size(), row(0, 0, 0, -1000, 0, 300, 0, 0, 0));
        rows.insert(rows.size(), row(100, 100, 50, 80, 1, 1024, 0, 0, 0));
        rows.insert(rows.size(), row(-32768, -32768, 32767, 32767, 1, 1024, 0, 0, 0));
        rows.insert(rows.size(), row(32767, -32768, -32768, 32767, 0, 2047, 0, 0, 0));
        rows.insert(rows.size(), row(0, 0, 3000, 4000, 1, 0, 0, 0, 0));
        rows.insert(rows.size(), row(-5000, 2000, 5000, -2000, 1, 1, 0, 0, 0));
        rows.insert(rows.size(), row(0, 0, 768, 1024, 0, 64, 0, 0, 0));
        rows.insert(rows.size(), row(-16000, 0, 16000, 0, 1, 1000, 0, 0, 0));
        rows.insert(rows.size(), row(0, 0, 63, 0, 1, 1, 0, 0, 0));
        rows.insert(rows.size(), row(0, 0, 64, 0, 0, 1, 0, 0, 0));
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
            send_segment(rows[i].s, rows[i].known, rows[i].p);
        for (int n = 0; n < RANDOM_SEGS; n++)
        begin
            if (n == RANDOM_SEGS - CALM_TAIL)
                calm = 1'b1;
            send_segment(random_segment(), 1'b0, '0);
        end
        seg_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (120)
            @(posedge clk);
        $display("Ran %0d segments, checked %0d points, %0d segments hit the point cap",
                 segs_sent, points_checked, cut_segments);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
